@@ hw/rtl/fpas_pkg.sv @@
// Package for the truncating single-precision add/subtract block.
// Field masks, widths and the command code. No dependencies.
`default_nettype none
package fpas_pkg;
    localparam int unsigned WordW  = 32;
    localparam int unsigned ExpW   = 8;
    localparam int unsigned FracW  = 23;
    localparam logic [ExpW-1:0] ExpMax = 8'hFF;

    typedef enum logic {
        CMD_ADD = 1'b0,
        CMD_SUB = 1'b1
    } cmd_t;
endpackage
`default_nettype wire

@@ hw/rtl/fpas_if.sv @@
// Handshake channels for the add/subtract block: operand item and result item.
// No dependencies.
`default_nettype none
interface fpas_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    modport source (output valid, command, operand_a, operand_b, input ready);
    modport sink   (input valid, command, operand_a, operand_b, output ready);
endinterface

interface fpas_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] sum_bits;
    modport source (output valid, sum_bits, input ready);
    modport sink   (input valid, sum_bits, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/fpas_core.sv @@
// Combinational datapath: align, add or subtract, normalize, truncate.
// Depends on fpas_pkg.
`default_nettype none
module fpas_core (
    input  wire logic        command,
    input  wire logic [31:0] operand_a,
    input  wire logic [31:0] operand_b,
    output logic      [31:0] sum_bits
);
    logic [31:0] b;
    logic        sa, sb, s;
    logic [7:0]  ea, eb, e;
    logic [23:0] ma, mb, big, sml;
    logic [7:0]  shift_amt;
    logic [24:0] m;
    logic [23:0] mn;
    logic [4:0]  lz;
    logic [7:0]  sh;
    logic        a_big;

    always_comb
    begin
        b  = operand_b ^ {(command == fpas_pkg::CMD_SUB), 31'b0};
        sa = operand_a[31];
        sb = b[31];
        ea = (operand_a[30:23] == 8'd0) ? 8'd1 : operand_a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma = {(operand_a[30:23] != 8'd0), operand_a[22:0]};
        mb = {(b[30:23] != 8'd0), b[22:0]};
        a_big = (ea > eb);
        shift_amt = a_big ? (ea - eb) : (eb - ea);
        e    = a_big ? ea : eb;
        big  = a_big ? ma : mb;
        sml  = a_big ? mb : ma;
        sml  = (shift_amt >= 8'd25) ? 24'd0 : (sml >> shift_amt);
        if (a_big)
        begin
            ma = big;
            mb = sml;
        end
        else
        begin
            ma = sml;
            mb = big;
        end
        s = sa;
        if (sa == sb)
            m = {1'b0, ma} + {1'b0, mb};
        else if (ma > mb)
            m = {1'b0, ma - mb};
        else
        begin
            m = {1'b0, mb - ma};
            s = sb;
        end
        lz = 5'd0;
        for (int i = 23; i >= 0; i--)
            if (m[i] && lz == 5'd0 && i != 23)
                lz = 5'(23 - i);
        if (m[23])
            lz = 5'd0;
        sh = ({3'b0, lz} < e) ? {3'b0, lz} : (e - 8'd1);
        mn = m[23:0] << sh;
        if (operand_a[30:23] == fpas_pkg::ExpMax)
            sum_bits = operand_a;
        else if (b[30:23] == fpas_pkg::ExpMax)
            sum_bits = b;
        else if (m[24])
        begin
            if (e + 8'd1 >= fpas_pkg::ExpMax)
                sum_bits = {s, fpas_pkg::ExpMax, 23'd0};
            else
                sum_bits = {s, e + 8'd1, m[23:1]};
        end
        else if (m == 25'd0)
            sum_bits = 32'd0;
        else
            sum_bits = {s, (mn[23] ? e - sh : 8'd0), mn[22:0]};
    end
endmodule
`default_nettype wire

@@ hw/rtl/fp32_add_sub_truncating.sv @@
// Top level of the truncating single-precision add/subtract block.
// Depends on fpas_pkg, fpas_if and fpas_core.
`default_nettype none
// One item per cycle while the sink does not stall: the operands are registered,
// the datapath runs one pass between the input and result registers, and
// the result register is held while the sink stalls. No rounding; NaN and
// infinity operands pass through; exact zeros come out as +0.
module fp32_add_sub_truncating (
    input wire logic  clk,
    input wire logic  rst_n,
    fpas_in_if.sink   in_ch,
    fpas_out_if.source out_ch
);
    logic        in_v_reg, out_v_reg;
    logic        cmd_reg;
    logic [31:0] a_reg, b_reg, res_reg, res_next;
    logic        adv;

    assign adv          = !out_v_reg || out_ch.ready;
    assign in_ch.ready  = !in_v_reg || adv;
    assign out_ch.valid = out_v_reg;
    assign out_ch.sum_bits = res_reg;

    fpas_core u_core (
        .command(cmd_reg), .operand_a(a_reg), .operand_b(b_reg), .sum_bits(res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
                in_v_reg <= in_ch.valid;
            if (adv)
                out_v_reg <= in_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            cmd_reg <= in_ch.command;
            a_reg   <= in_ch.operand_a;
            b_reg   <= in_ch.operand_b;
        end
        if (adv && in_v_reg)
            res_reg <= res_next;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && !out_ch.ready |=> out_v_reg && $stable(res_reg))
        else $error("result dropped while stalled");
    a_move: assert property (@(posedge clk) disable iff (!rst_n)
        in_v_reg && adv |=> out_v_reg)
        else $error("item lost between stages");
endmodule
`default_nettype wire

@@ bench/fp32_add_sub_truncating_test.sv @@
// Self-checking bench for fp32_add_sub_truncating: directed and random add/subtract
// items against a local truncating-adder predictor. Depends on fpas_pkg, fpas_if, RTL.
`timescale 1ns / 1ps
module fp32_add_sub_truncating_test;
    typedef struct packed {
        fpas_pkg::cmd_t command;
        logic [31:0]    operand_a;
        logic [31:0]    operand_b;
    } op_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fpas_in_if  in_ch ();
    fpas_out_if out_ch ();

    fp32_add_sub_truncating i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    op_item_t    pending_ops[$];
    logic [31:0] expected_sums[$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles = 0;
    longint      cycle_count = 0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Truncating single-precision add; b already has the subtract applied.
    function automatic logic [31:0] trunc_add(logic [31:0] a, logic [31:0] b);
        logic        sa, sb, s;
        logic [8:0]  ea, eb, e, gap;
        logic [24:0] ma, mb, m;
        sa = a[31];
        sb = b[31];
        ea = {1'b0, a[30:23]};
        eb = {1'b0, b[30:23]};
        ma = {2'b00, a[22:0]};
        mb = {2'b00, b[22:0]};
        if (a[30:23] == fpas_pkg::ExpMax) return a;
        if (b[30:23] == fpas_pkg::ExpMax) return b;
        if (ea != 9'd0) ma[23] = 1'b1; else ea = 9'd1;
        if (eb != 9'd0) mb[23] = 1'b1; else eb = 9'd1;
        if (ea > eb)
        begin
            gap = ea - eb;
            mb = (gap >= 9'd25) ? '0 : (mb >> gap);
            e = ea;
        end
        else
        begin
            gap = eb - ea;
            ma = (gap >= 9'd25) ? '0 : (ma >> gap);
            e = eb;
        end
        if (sa == sb)
        begin
            m = ma + mb;
            s = sa;
            if (m[24])
            begin
                m = m >> 1;
                e = e + 9'd1;
                if (e >= 9'd255) return {s, 8'hFF, 23'd0};
            end
        end
        else if (ma > mb)
        begin
            m = ma - mb;
            s = sa;
        end
        else
        begin
            m = mb - ma;
            s = sb;
        end
        if (m == 25'd0) return 32'd0;
        while (!m[23] && e > 9'd1)
        begin
            m = m << 1;
            e = e - 9'd1;
        end
        if (!m[23]) e = 9'd0;
        return {s, e[7:0], m[22:0]};
    endfunction

    function automatic logic [31:0] rand_float();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0: w[30:23] = 8'h00;
            1: w[30:23] = 8'hFF;
            2: w[30:23] = 8'hFE;
            3: w[22:0] = '0;
            default: w[30:23] = 8'd120 + 8'($urandom_range(0, 16));
        endcase
        return w;
    endfunction

    task automatic queue_op(fpas_pkg::cmd_t c, logic [31:0] a, logic [31:0] b);
        pending_ops.push_back('{c, a, b});
    endtask

    task automatic drain();
        while (pending_ops.size() != 0 || in_ch.valid || expected_sums.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid     <= 1'b0;
            in_ch.command   <= fpas_pkg::CMD_ADD;
            in_ch.operand_a <= '0;
            in_ch.operand_b <= '0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (in_ch.valid)
            begin
                expected_sums.push_back(trunc_add(in_ch.operand_a,
                    in_ch.command == fpas_pkg::CMD_SUB ? in_ch.operand_b ^ 32'h8000_0000
                                                       : in_ch.operand_b));
            end
            if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                op_item_t it;
                it = pending_ops.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.command   <= it.command;
                in_ch.operand_a <= it.operand_a;
                in_ch.operand_b <= it.operand_b;
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver stalls, with a forced hold-off window
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles  <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_sums.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", out_ch.sum_bits);
            end
            else
            begin
                logic [31:0] want;
                want = expected_sums.pop_front();
                if (out_ch.sum_bits !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("sum_bits mismatch: expected %h got %h",
                                 want, out_ch.sum_bits);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, specials, cancellation, overflow, subnormals
        queue_op(fpas_pkg::CMD_ADD, 32'h0000_0000, 32'h0000_0000);
        queue_op(fpas_pkg::CMD_ADD, 32'h8000_0000, 32'h8000_0000);
        queue_op(fpas_pkg::CMD_SUB, 32'h3F80_0000, 32'h3F80_0000);
        queue_op(fpas_pkg::CMD_ADD, 32'h3F80_0000, 32'hBF80_0000);
        queue_op(fpas_pkg::CMD_ADD, 32'h7F80_0000, 32'hFF80_0000);
        queue_op(fpas_pkg::CMD_SUB, 32'h7FC0_0001, 32'h3F80_0000);
        queue_op(fpas_pkg::CMD_SUB, 32'h3F80_0000, 32'h7F80_0000);
        queue_op(fpas_pkg::CMD_ADD, 32'h4000_0000, 32'hFFFF_FFFF);
        queue_op(fpas_pkg::CMD_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
        queue_op(fpas_pkg::CMD_SUB, 32'hFF7F_FFFF, 32'h7F7F_FFFF);
        queue_op(fpas_pkg::CMD_ADD, 32'h0000_0001, 32'h0000_0001);
        queue_op(fpas_pkg::CMD_ADD, 32'h007F_FFFF, 32'h0000_0001);
        queue_op(fpas_pkg::CMD_SUB, 32'h0080_0000, 32'h0000_0001);
        queue_op(fpas_pkg::CMD_ADD, 32'h3F80_0000, 32'h3300_0000);
        queue_op(fpas_pkg::CMD_ADD, 32'h3F80_0000, 32'h3280_0000);
        queue_op(fpas_pkg::CMD_SUB, 32'h3F80_0000, 32'h3F7F_FFFF);
        queue_op(fpas_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_op(fpas_pkg::CMD_SUB, 32'h4B80_0000, 32'h3F80_0000);
        queue_op(fpas_pkg::CMD_ADD, 32'h5555_5555, 32'hAAAA_AAAA);
        queue_op(fpas_pkg::CMD_SUB, 32'hAAAA_AAAA, 32'h5555_5555);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 19 : 77) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 19 : 77) : 0;
            for (int k = 0; k < 450; k++)
                queue_op(fpas_pkg::cmd_t'($urandom_range(0, 1)), rand_float(), rand_float());
            if (phase == 0)
                hold_cycles <= 300;
            drain();
        end

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

@@ fp32_add_sub_truncating.f @@
hw/rtl/fpas_pkg.sv
hw/rtl/fpas_if.sv
hw/rtl/fpas_core.sv
hw/rtl/fp32_add_sub_truncating.sv
bench/fp32_add_sub_truncating_test.sv
